// ===== src/gcss_pkg.sv =====
`timescale 1ns / 1ps

package gcss_pkg;

  // Operation codes carried in the operation field
  localparam logic [1:0] OP_READ = 2'd0;
  localparam logic [1:0] OP_SWAP = 2'd1;
  localparam logic [1:0] OP_TAIL = 2'd2;
  localparam logic [1:0] OP_LOAD = 2'd3;

  localparam int STEP_W = 4;

  // Program steps
  localparam logic [STEP_W-1:0] ST_IDLE    = 4'd0;
  localparam logic [STEP_W-1:0] ST_CHECK   = 4'd1;
  localparam logic [STEP_W-1:0] ST_BASE    = 4'd2;
  localparam logic [STEP_W-1:0] ST_PTR     = 4'd3;
  localparam logic [STEP_W-1:0] ST_DISP    = 4'd4;
  localparam logic [STEP_W-1:0] ST_LOAD    = 4'd5;
  localparam logic [STEP_W-1:0] ST_RD_ISS  = 4'd9;
  localparam logic [STEP_W-1:0] ST_RD_CAP  = 4'd10;
  localparam logic [STEP_W-1:0] ST_XCH_RP  = 4'd11;
  localparam logic [STEP_W-1:0] ST_XCH_RQ  = 4'd12;
  localparam logic [STEP_W-1:0] ST_XCH_WP  = 4'd13;
  localparam logic [STEP_W-1:0] ST_XCH_WQ  = 4'd14;
  localparam logic [STEP_W-1:0] ST_RESULT  = 4'd15;

  // Jump conditions
  localparam logic [2:0] COND_NONE     = 3'd0;
  localparam logic [2:0] COND_ALWAYS   = 3'd1;
  localparam logic [2:0] COND_NO_INPUT = 3'd2;
  localparam logic [2:0] COND_BAD      = 3'd3;
  localparam logic [2:0] COND_OP_READ  = 3'd4;
  localparam logic [2:0] COND_OP_XCH   = 3'd5;
  localparam logic [2:0] COND_MORE     = 3'd6;
  localparam logic [2:0] COND_OUT_BUSY = 3'd7;

  // Memory read address select
  localparam logic [1:0] RD_NONE = 2'd0;
  localparam logic [1:0] RD_P    = 2'd1;
  localparam logic [1:0] RD_Q    = 2'd2;

  // Memory write select
  localparam logic [1:0] WR_NONE   = 2'd0;
  localparam logic [1:0] WR_P_RD   = 2'd1;
  localparam logic [1:0] WR_Q_TMP  = 2'd2;
  localparam logic [1:0] WR_P_LOAD = 2'd3;

  typedef struct packed {
    logic              accept;
    logic              calc_cell;
    logic              calc_base;
    logic              calc_ptr;
    logic [1:0]        rd_sel;
    logic              tmp_load;
    logic [1:0]        wr_sel;
    logic              word_cap;
    logic              advance;
    logic              out_load;
    logic [2:0]        cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  // Control store: one word per step. A taken jump goes to target,
  // otherwise the step counter advances by one (ST_RESULT wraps to ST_IDLE).
  function automatic ctrl_t ctrl_rom(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c = '0;
    unique case (step)
      ST_IDLE: begin
        c.accept = 1'b1;
        c.cond   = COND_NO_INPUT;
        c.target = ST_IDLE;
      end
      ST_CHECK: begin
        c.calc_cell = 1'b1;
        c.cond      = COND_BAD;
        c.target    = ST_RESULT;
      end
      ST_BASE: begin
        c.calc_base = 1'b1;
      end
      ST_PTR: begin
        c.calc_ptr = 1'b1;
        c.cond     = COND_OP_READ;
        c.target   = ST_RD_ISS;
      end
      ST_DISP: begin
        c.cond   = COND_OP_XCH;
        c.target = ST_XCH_RP;
      end
      ST_LOAD: begin
        c.wr_sel = WR_P_LOAD;
        c.cond   = COND_ALWAYS;
        c.target = ST_RESULT;
      end
      ST_RD_ISS: begin
        c.rd_sel = RD_P;
      end
      ST_RD_CAP: begin
        c.word_cap = 1'b1;
        c.cond     = COND_ALWAYS;
        c.target   = ST_RESULT;
      end
      ST_XCH_RP: begin
        c.rd_sel = RD_P;
      end
      ST_XCH_RQ: begin
        c.rd_sel   = RD_Q;
        c.tmp_load = 1'b1;
      end
      ST_XCH_WP: begin
        c.wr_sel = WR_P_RD;
      end
      ST_XCH_WQ: begin
        c.wr_sel  = WR_Q_TMP;
        c.advance = 1'b1;
        c.cond    = COND_MORE;
        c.target  = ST_XCH_RP;
      end
      ST_RESULT: begin
        c.out_load = 1'b1;
        c.cond     = COND_OUT_BUSY;
        c.target   = ST_RESULT;
      end
      default: begin
        c.cond   = COND_ALWAYS;
        c.target = ST_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== src/grid_command_store_swap_core.sv =====
`timescale 1ns / 1ps

// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+---------------------------------------------
// in_      | input     | in_valid/in_stall   | operation, x_a, y_a, slot_a, x_b, y_b,
//          |           |                     | slot_b, load_word
// out_     | output    | out_valid/out_stall | ok, error_code, read_word
//
// One item at a time. A rejected address goes from its check straight to the result step;
// a read captures a word, a load writes one, and a swap or tail swap of n pairs (at most
// SLOTS_PER_CELL) exchanges pair by pair; the single-port memory, one read or write
// per cycle, makes each pair read p, read q, write p, write q. The next item is taken in
// the cycle after the result is registered; a stalled result holds the sequencer in its
// result step. rst_n is synchronous; it clears the sequencer and out_valid, not the memory.

module grid_command_store_swap_core #(
  parameter int GRID_COLUMNS   = 16,
  parameter int GRID_ROWS      = 16,
  parameter int SLOTS_PER_CELL = 16,
  parameter int COMMAND_BITS   = 8
) (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_x_a,
  input  logic [7:0] in_y_a,
  input  logic [7:0] in_slot_a,
  input  logic [7:0] in_x_b,
  input  logic [7:0] in_y_b,
  input  logic [7:0] in_slot_b,
  input  logic [7:0] in_load_word,

  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_ok,
  output logic       out_error_code,
  output logic [7:0] out_read_word
);

  localparam int CELLS  = GRID_COLUMNS * GRID_ROWS;
  localparam int DEPTH  = CELLS * SLOTS_PER_CELL;
  localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(SLOTS_PER_CELL + 1);

  // Sequencer
  logic [gcss_pkg::STEP_W-1:0] step_r, step_nxt;
  gcss_pkg::ctrl_t             cw;
  logic                        jump;

  // Latched item
  logic [1:0] op_r;
  logic [7:0] x_a_r, y_a_r, slot_a_r, x_b_r, y_b_r, slot_b_r, load_word_r;

  // Datapath registers
  logic [CELL_W-1:0] cell_a_r, cell_b_r;
  logic [AW-1:0]     base_a_r, base_b_r;
  logic [AW-1:0]     p_r, q_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              bad_r;
  logic [7:0]        word_r;
  logic [COMMAND_BITS-1:0] tmp_r;
  logic [COMMAND_BITS-1:0] rd_data_r;

  // Command memory
  logic [COMMAND_BITS-1:0] cmd_mem [DEPTH];

  // Output register
  logic       out_valid_r;
  logic       out_ok_r;
  logic       out_error_code_r;
  logic [7:0] out_read_word_r;

  logic accept;
  logic out_busy;
  logic bad;
  logic a_ok, b_ok, uses_b;
  logic is_tail, b_bigger;
  logic [16:0] cell_a_full, cell_b_full;
  logic [24:0] base_a_full, base_b_full;
  logic [8:0]  run_len;
  logic [COMMAND_BITS+7:0] rd_ext;
  logic [COMMAND_BITS+7:0] load_ext;
  logic                    mem_rd_en, mem_wr_en;
  logic [AW-1:0]           mem_rd_addr, mem_wr_addr;
  logic [COMMAND_BITS-1:0] mem_wr_data;

  assign cw       = gcss_pkg::ctrl_rom(step_r);
  assign accept   = in_valid && cw.accept;
  assign in_stall = !cw.accept;
  assign out_busy = out_valid_r && out_stall;

  // Address checks; the second address counts only for the two swaps
  assign a_ok   = (9'(x_a_r) < 9'(GRID_COLUMNS)) && (9'(y_a_r) < 9'(GRID_ROWS)) &&
                  (9'(slot_a_r) < 9'(SLOTS_PER_CELL));
  assign b_ok   = (9'(x_b_r) < 9'(GRID_COLUMNS)) && (9'(y_b_r) < 9'(GRID_ROWS)) &&
                  (9'(slot_b_r) < 9'(SLOTS_PER_CELL));
  assign uses_b = (op_r == gcss_pkg::OP_SWAP) || (op_r == gcss_pkg::OP_TAIL);
  assign bad    = !a_ok || (uses_b && !b_ok);

  // Cell index, then word base: one multiply by a constant per address and step
  assign cell_a_full = 17'(y_a_r) * 17'(GRID_COLUMNS) + 17'(x_a_r);
  assign cell_b_full = 17'(y_b_r) * 17'(GRID_COLUMNS) + 17'(x_b_r);
  assign base_a_full = 25'(cell_a_r) * 25'(SLOTS_PER_CELL);
  assign base_b_full = 25'(cell_b_r) * 25'(SLOTS_PER_CELL);

  // Tail swap walks from the larger slot to the end of its cell
  assign is_tail  = (op_r == gcss_pkg::OP_TAIL);
  assign b_bigger = is_tail && (slot_a_r < slot_b_r);
  assign run_len  = 9'(SLOTS_PER_CELL) - (b_bigger ? {1'b0, slot_b_r} : {1'b0, slot_a_r});

  // Jump condition
  always_comb begin
    unique case (cw.cond)
      gcss_pkg::COND_NONE:     jump = 1'b0;
      gcss_pkg::COND_ALWAYS:   jump = 1'b1;
      gcss_pkg::COND_NO_INPUT: jump = !in_valid;
      gcss_pkg::COND_BAD:      jump = bad;
      gcss_pkg::COND_OP_READ:  jump = (op_r == gcss_pkg::OP_READ);
      gcss_pkg::COND_OP_XCH:   jump = uses_b;
      gcss_pkg::COND_MORE:     jump = (cnt_r != CNT_W'(1));
      gcss_pkg::COND_OUT_BUSY: jump = out_busy;
      default:                 jump = 1'b0;
    endcase
    step_nxt = jump ? cw.target : step_r + gcss_pkg::STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= gcss_pkg::ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  // Latch the item and clear the returned word
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r        <= in_operation;
      x_a_r       <= in_x_a;
      y_a_r       <= in_y_a;
      slot_a_r    <= in_slot_a;
      x_b_r       <= in_x_b;
      y_b_r       <= in_y_b;
      slot_b_r    <= in_slot_b;
      load_word_r <= in_load_word;
    end
  end

  assign rd_ext   = {8'd0, rd_data_r};
  assign load_ext = {{COMMAND_BITS{1'b0}}, load_word_r};

  always_ff @(posedge clk) begin
    if (accept) begin
      word_r <= 8'd0;
    end else if (cw.word_cap) begin
      word_r <= rd_ext[7:0];
    end
    if (cw.calc_cell) begin
      cell_a_r <= cell_a_full[CELL_W-1:0];
      cell_b_r <= cell_b_full[CELL_W-1:0];
      bad_r    <= bad;
    end
    if (cw.calc_base) begin
      base_a_r <= base_a_full[AW-1:0];
      base_b_r <= base_b_full[AW-1:0];
    end
    if (cw.calc_ptr) begin
      // p walks the run at the larger slot (tail swap only; else p is address a), q the other
      if (b_bigger) begin
        p_r <= base_b_r + AW'(slot_b_r);
        q_r <= base_a_r + AW'(slot_a_r);
      end else begin
        p_r <= base_a_r + AW'(slot_a_r);
        q_r <= base_b_r + AW'(slot_b_r);
      end
      cnt_r <= is_tail ? run_len[CNT_W-1:0] : CNT_W'(1);
    end else if (cw.advance) begin
      p_r   <= p_r + AW'(1);
      q_r   <= q_r + AW'(1);
      cnt_r <= cnt_r - CNT_W'(1);
    end
    if (cw.tmp_load) begin
      tmp_r <= rd_data_r;
    end
  end

  // Memory port: one read or one write per step
  always_comb begin
    mem_rd_en   = (cw.rd_sel != gcss_pkg::RD_NONE);
    mem_rd_addr = (cw.rd_sel == gcss_pkg::RD_Q) ? q_r : p_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = p_r;
    mem_wr_data = rd_data_r;
    unique case (cw.wr_sel)
      gcss_pkg::WR_NONE: begin
        mem_wr_en = 1'b0;
      end
      gcss_pkg::WR_P_RD: begin
        mem_wr_en = 1'b1;
      end
      gcss_pkg::WR_Q_TMP: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = q_r;
        mem_wr_data = tmp_r;
      end
      gcss_pkg::WR_P_LOAD: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = load_ext[COMMAND_BITS-1:0];
      end
      default: begin
        mem_wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      cmd_mem[mem_wr_addr] <= mem_wr_data;
    end
    if (mem_rd_en) begin
      rd_data_r <= cmd_mem[mem_rd_addr];
    end
  end

  // Result register: drop the old item when taken, load the new one when free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cw.out_load && !out_busy) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.out_load && !out_busy) begin
      out_ok_r         <= !bad_r;
      out_error_code_r <= bad_r;
      out_read_word_r  <= bad_r ? 8'd0 : word_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_error_code = out_error_code_r;
  assign out_read_word  = out_read_word_r;

endmodule

// ===== src/gcss_checker.sv =====
`timescale 1ns / 1ps

module gcss_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_ok,
  input logic       out_error_code,
  input logic [7:0] out_read_word
);

  // ok and error flag always disagree
  a_ok_xor_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ok != out_error_code))
    else $error("ok and error_code agree");

  // a failed item returns no word
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_read_word == 8'd0))
    else $error("failed item returned a word");

  // one item at a time: input closes right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item accepted back to back");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_ok) &&
      $stable(out_error_code) && $stable(out_read_word)))
    else $error("stalled result changed");

endmodule

bind grid_command_store_swap_core gcss_checker u_gcss_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_ok         (out_ok),
  .out_error_code (out_error_code),
  .out_read_word  (out_read_word)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

// Check the grid command store against a local predictor.
//
// Flow: an initial block plans every item up front into pending_commands. The
// planner keeps its own image of the store, so it knows which entries hold a
// written word. A read is aimed only at such an entry. The driver presents
// items from the queue. On each accepted item it runs the same predictor on a
// second image and queues the expected result. The monitor compares every
// accepted result, field by field, with the oldest expectation.
module tb_top;

  localparam int GRID_COLUMNS   = 16;
  localparam int GRID_ROWS      = 16;
  localparam int SLOTS_PER_CELL = 16;
  localparam int COMMAND_BITS   = 8;
  localparam int STORE_DEPTH    = GRID_COLUMNS * GRID_ROWS * SLOTS_PER_CELL;
  localparam int LAST_COL       = GRID_COLUMNS - 1;
  localparam int LAST_ROW       = GRID_ROWS - 1;
  localparam int LAST_SLOT      = SLOTS_PER_CELL - 1;

  // Two images of the store: one follows the plan, one follows accepted items
  localparam int PLAN_IMAGE  = 0;
  localparam int MODEL_IMAGE = 1;

  localparam int RANDOM_ITEMS   = 1750;
  localparam int ITEMS_PER_PASE = 150;
  localparam int DRAIN_CYCLES   = 80;   // longest tail swap plus margin
  localparam int HOLD_OFF_AT    = 400;  // accepted items before the long stall
  localparam int HOLD_OFF_LEN   = 300;
  localparam int REPORT_LIMIT   = 40;

  // Idle and stall percentages per traffic phase: none, sender, receiver, both
  localparam int SEND_IDLE_PCT  [4] = '{0, 64, 0, 36};
  localparam int RECV_STALL_PCT [4] = '{0, 0, 64, 36};

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] x_a;
    logic [7:0] y_a;
    logic [7:0] slot_a;
    logic [7:0] x_b;
    logic [7:0] y_b;
    logic [7:0] slot_b;
    logic [7:0] load_word;
  } command_t;

  typedef struct packed {
    bit       ok;
    bit       error_code;
    bit [7:0] read_word;
  } result_t;

  typedef struct packed {
    bit [COMMAND_BITS-1:0] word;
    bit                    known;  // marks an entry holding a loaded word; swaps move it with the word
  } store_entry_t;

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic       in_stall;
  logic [1:0] in_operation   = gcss_pkg::OP_READ;
  logic [7:0] in_x_a         = '0;
  logic [7:0] in_y_a         = '0;
  logic [7:0] in_slot_a      = '0;
  logic [7:0] in_x_b         = '0;
  logic [7:0] in_y_b         = '0;
  logic [7:0] in_slot_b      = '0;
  logic [7:0] in_load_word   = '0;
  logic       out_valid;
  logic       out_stall      = 1'b0;
  logic       out_ok;
  logic       out_error_code;
  logic [7:0] out_read_word;

  store_entry_t command_image [2][STORE_DEPTH];
  command_t     pending_commands [$];
  result_t      expected_results [$];
  int           accepted_count = 0;
  int           mismatch_count = 0;
  int           traffic_phase;
  logic         hold_off = 1'b0;

  grid_command_store_swap_core #(
    .GRID_COLUMNS  (GRID_COLUMNS),
    .GRID_ROWS     (GRID_ROWS),
    .SLOTS_PER_CELL(SLOTS_PER_CELL),
    .COMMAND_BITS  (COMMAND_BITS)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_x_a        (in_x_a),
    .in_y_a        (in_y_a),
    .in_slot_a     (in_slot_a),
    .in_x_b        (in_x_b),
    .in_y_b        (in_y_b),
    .in_slot_b     (in_slot_b),
    .in_load_word  (in_load_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_ok        (out_ok),
    .out_error_code(out_error_code),
    .out_read_word (out_read_word)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Rotate through the traffic phases as items are accepted
  always_comb traffic_phase = (accepted_count / ITEMS_PER_PASE) % 4;

  function automatic bit in_grid(logic [7:0] x, logic [7:0] y, logic [7:0] s);
    return x < GRID_COLUMNS && y < GRID_ROWS && s < SLOTS_PER_CELL;
  endfunction

  function automatic int store_index(logic [7:0] x, logic [7:0] y, logic [7:0] s);
    return (int'(y) * GRID_COLUMNS + int'(x)) * SLOTS_PER_CELL + int'(s);
  endfunction

  // Apply one item to the chosen image and return the result it produces.
  function automatic result_t apply_command(int image, command_t c);
    result_t      r;
    bit           legal;
    int           base_a;
    int           base_b;
    int           long_base;
    int           short_base;
    int           long_slot;
    int           short_slot;
    int           side_p [$];
    int           side_q [$];
    store_entry_t held;
    legal = in_grid(c.x_a, c.y_a, c.slot_a);
    // The second address matters only to the two swap operations
    if (c.operation == gcss_pkg::OP_SWAP || c.operation == gcss_pkg::OP_TAIL)
      legal = legal && in_grid(c.x_b, c.y_b, c.slot_b);
    r.ok         = legal;
    r.error_code = !legal;
    r.read_word  = '0;
    if (legal) begin
      base_a = store_index(c.x_a, c.y_a, 8'd0);
      base_b = store_index(c.x_b, c.y_b, 8'd0);
      case (c.operation)
        gcss_pkg::OP_READ:
          r.read_word = 8'(command_image[image][base_a + int'(c.slot_a)].word);
        gcss_pkg::OP_LOAD: begin
          command_image[image][base_a + int'(c.slot_a)].word  = c.load_word[COMMAND_BITS-1:0];
          command_image[image][base_a + int'(c.slot_a)].known = 1'b1;
        end
        gcss_pkg::OP_SWAP: begin
          side_p.push_back(base_a + int'(c.slot_a));
          side_q.push_back(base_b + int'(c.slot_b));
        end
        gcss_pkg::OP_TAIL: begin
          // The run starts at the larger slot and ends at the end of its cell
          if (c.slot_a >= c.slot_b) begin
            long_base  = base_a;
            long_slot  = int'(c.slot_a);
            short_base = base_b;
            short_slot = int'(c.slot_b);
          end else begin
            long_base  = base_b;
            long_slot  = int'(c.slot_b);
            short_base = base_a;
            short_slot = int'(c.slot_a);
          end
          for (int k = long_slot; k < SLOTS_PER_CELL; k++) begin
            side_p.push_back(long_base + k);
            side_q.push_back(short_base + short_slot + k - long_slot);
          end
        end
      endcase
      // Exchange pair by pair in order; overlapping runs in one cell depend on it
      foreach (side_p[i]) begin
        held                              = command_image[image][side_p[i]];
        command_image[image][side_p[i]]   = command_image[image][side_q[i]];
        command_image[image][side_q[i]]   = held;
      end
    end
    return r;
  endfunction

  task automatic queue_command(input command_t c);
    pending_commands.push_back(c);
    void'(apply_command(PLAN_IMAGE, c));
  endtask

  task automatic queue_direct(input logic [1:0] op, input int xa, input int ya, input int sa,
                              input int xb, input int yb, input int sb, input int word);
    command_t c;
    c = '{operation: op, x_a: 8'(xa), y_a: 8'(ya), slot_a: 8'(sa),
          x_b: 8'(xb), y_b: 8'(yb), slot_b: 8'(sb), load_word: 8'(word)};
    queue_command(c);
  endtask

  // Favor a few cells so reads and swaps keep hitting written words
  task automatic pick_address(output logic [7:0] x, output logic [7:0] y,
                              output logic [7:0] s);
    if ($urandom_range(99) < 70) begin
      x = 8'($urandom_range(3));
      y = 8'($urandom_range(3));
    end else begin
      x = 8'($urandom_range(LAST_COL));
      y = 8'($urandom_range(LAST_ROW));
    end
    s = 8'($urandom_range(LAST_SLOT));
  endtask

  function automatic logic [7:0] beyond(int bound);
    return 8'($urandom_range(255, bound));
  endfunction

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    if (mismatch_count < REPORT_LIMIT)
      $display("%0t: wrong %s: got %0h, expected %0h", $realtime, field, got, want);
    mismatch_count++;
  endtask

  // Driver: predict on every accepted item, then offer the next one or idle.
  always @(posedge clk) begin : drive_items
    command_t presented;
    command_t next_cmd;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        presented = '{operation: in_operation, x_a: in_x_a, y_a: in_y_a,
                      slot_a: in_slot_a, x_b: in_x_b, y_b: in_y_b,
                      slot_b: in_slot_b, load_word: in_load_word};
        expected_results.push_back(apply_command(MODEL_IMAGE, presented));
        accepted_count++;
      end
      // Hold a stalled item; otherwise the slot is free for a new one
      if (!in_valid || !in_stall) begin
        if (pending_commands.size() > 0 &&
            $urandom_range(99) >= SEND_IDLE_PCT[traffic_phase]) begin
          next_cmd = pending_commands.pop_front();
          in_operation <= next_cmd.operation;
          in_x_a       <= next_cmd.x_a;
          in_y_a       <= next_cmd.y_a;
          in_slot_a    <= next_cmd.slot_a;
          in_x_b       <= next_cmd.x_b;
          in_y_b       <= next_cmd.y_b;
          in_slot_b    <= next_cmd.slot_b;
          in_load_word <= next_cmd.load_word;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result, then pick the stall for next cycle.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing pending, read_word", out_read_word, 8'h00);
        end else begin
          want = expected_results.pop_front();
          if (out_ok !== want.ok)
            report_mismatch("ok", 8'(out_ok), 8'(want.ok));
          if (out_error_code !== want.error_code)
            report_mismatch("error_code", 8'(out_error_code), 8'(want.error_code));
          if (out_read_word !== want.read_word)
            report_mismatch("read_word", out_read_word, want.read_word);
        end
      end
      out_stall <= hold_off || ($urandom_range(99) < RECV_STALL_PCT[traffic_phase]);
    end
  end

  // Long receiver hold-off: the block parks on its result and stalls its input
  // while the driver keeps offering.
  initial begin : long_hold_off
    while (accepted_count < HOLD_OFF_AT) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_LEN) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : stimulus
    command_t c;
    int       roll;
    int       pick;
    bit       found;

    // Directed part: fill the corners, read two back, then error paths on both addresses
    queue_direct(gcss_pkg::OP_LOAD, 0, 0, 0, 0, 0, 0, 'h00);
    queue_direct(gcss_pkg::OP_LOAD, LAST_COL, LAST_ROW, LAST_SLOT, 0, 0, 0, 'hFF);
    queue_direct(gcss_pkg::OP_LOAD, 0, 0, LAST_SLOT, 0, 0, 0, 'hA5);
    queue_direct(gcss_pkg::OP_LOAD, LAST_COL, LAST_ROW, 0, 0, 0, 0, 'h5A);
    // Second address on read and load is junk and must be ignored
    queue_direct(gcss_pkg::OP_READ, 0, 0, 0, 255, 255, 255, 0);
    queue_direct(gcss_pkg::OP_READ, LAST_COL, LAST_ROW, LAST_SLOT, 0, 0, 0, 0);
    queue_direct(gcss_pkg::OP_LOAD, 1, 0, 3, 255, 255, 255, 'h3C);
    // Invalid column, row and slot: nothing changes; then a legal swap and its read-back
    queue_direct(gcss_pkg::OP_READ, GRID_COLUMNS, 0, 0, 0, 0, 0, 0);
    queue_direct(gcss_pkg::OP_READ, 0, 255, 0, 0, 0, 0, 0);
    queue_direct(gcss_pkg::OP_LOAD, 0, 0, SLOTS_PER_CELL, 0, 0, 0, 'h77);
    queue_direct(gcss_pkg::OP_SWAP, 0, 0, 0, LAST_COL, LAST_ROW, LAST_SLOT, 0);
    queue_direct(gcss_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0);
    // Swap of one address with itself leaves the word alone
    queue_direct(gcss_pkg::OP_SWAP, 0, 0, LAST_SLOT, 0, 0, LAST_SLOT, 0);
    queue_direct(gcss_pkg::OP_READ, 0, 0, LAST_SLOT, 0, 0, 0, 0);
    queue_direct(gcss_pkg::OP_SWAP, 0, 0, 0, 255, 0, 0, 0);
    queue_direct(gcss_pkg::OP_TAIL, 0, 0, 0, 0, 0, SLOTS_PER_CELL, 0);
    // Tail swaps: first slot larger, second slot larger, overlap in one cell
    queue_direct(gcss_pkg::OP_TAIL, 0, 0, LAST_SLOT, LAST_COL, LAST_ROW, 0, 0);
    queue_direct(gcss_pkg::OP_TAIL, LAST_COL, LAST_ROW, 0, 1, 0, 3, 0);
    queue_direct(gcss_pkg::OP_READ, LAST_COL, LAST_ROW, 0, 0, 0, 0, 0);
    queue_direct(gcss_pkg::OP_READ, 1, 0, 3, 0, 0, 0, 0);
    queue_direct(gcss_pkg::OP_TAIL, 0, 0, 2, 0, 0, 0, 0);
    queue_direct(gcss_pkg::OP_READ, 0, 0, LAST_SLOT - 1, 0, 0, 0, 0);
    queue_direct(gcss_pkg::OP_READ, 0, 0, LAST_SLOT - 2, 0, 0, 0, 0);

    // Random part: mostly legal traffic on a busy region, some broken items
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      c.x_b       = 8'($urandom);
      c.y_b       = 8'($urandom);
      c.slot_b    = 8'($urandom);
      c.load_word = 8'($urandom);
      pick_address(c.x_a, c.y_a, c.slot_a);
      roll = $urandom_range(99);
      if (roll < 8) begin
        // Broken item: push one used coordinate out of the grid
        c.operation = 2'($urandom_range(3));
        if (c.operation == gcss_pkg::OP_SWAP || c.operation == gcss_pkg::OP_TAIL) begin
          pick_address(c.x_b, c.y_b, c.slot_b);
          pick = $urandom_range(5);
        end else begin
          pick = $urandom_range(2);
        end
        case (pick)
          0: c.x_a    = beyond(GRID_COLUMNS);
          1: c.y_a    = beyond(GRID_ROWS);
          2: c.slot_a = beyond(SLOTS_PER_CELL);
          3: c.x_b    = beyond(GRID_COLUMNS);
          4: c.y_b    = beyond(GRID_ROWS);
          default: c.slot_b = beyond(SLOTS_PER_CELL);
        endcase
      end else if (roll < 33) begin
        c.operation = gcss_pkg::OP_LOAD;
      end else if (roll < 63) begin
        // Aim the read at a written entry; load instead if none turns up
        found = command_image[PLAN_IMAGE][store_index(c.x_a, c.y_a, c.slot_a)].known;
        for (int t = 0; t < 32 && !found; t++) begin
          pick_address(c.x_a, c.y_a, c.slot_a);
          found = command_image[PLAN_IMAGE][store_index(c.x_a, c.y_a, c.slot_a)].known;
        end
        c.operation = found ? gcss_pkg::OP_READ : gcss_pkg::OP_LOAD;
      end else begin
        c.operation = (roll < 81) ? gcss_pkg::OP_SWAP : gcss_pkg::OP_TAIL;
        pick_address(c.x_b, c.y_b, c.slot_b);
        // Keep both addresses in one cell now and then
        if ($urandom_range(99) < 25) begin
          c.x_b = c.x_a;
          c.y_b = c.y_a;
        end
      end
      queue_command(c);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: every item out, every result back, then a quiet spell
    do @(posedge clk);
    while (pending_commands.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("grid_command_store_swap_core: match");
    else
      $display("grid_command_store_swap_core: mismatch");
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("grid_command_store_swap_core: mismatch");
    $finish;
  end

endmodule

// ===== grid_command_store_swap_core.f =====
src/gcss_pkg.sv
src/grid_command_store_swap_core.sv
src/gcss_checker.sv
tb/tb_top.sv
